// ===== hdl/gha_pkg.sv =====
package gha_pkg;

  localparam int INDEX_WIDTH  = 12;
  localparam int GEN_WIDTH    = 8;
  localparam int HANDLE_WIDTH = INDEX_WIDTH + GEN_WIDTH;
  localparam int COUNT_WIDTH  = INDEX_WIDTH + 1;
  localparam int CMD_WIDTH    = 2;
  localparam int STATUS_WIDTH = 2;

  localparam logic [COUNT_WIDTH-1:0] SLOT_COUNT  = COUNT_WIDTH'(1) << INDEX_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] REUSE_RESET = COUNT_WIDTH'(1024);

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_ALIVE   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK   = 2'd0,
    ST_DEAD = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // latch the request beat and launch the first reads
    logic gen_fetch;  // read the generation of the slot popped from the free queue
    logic exec;       // commit the update and load the response register
  } ctl_cmd_t;

  // Datapath to controller (and counters for checking).
  typedef struct packed {
    logic                   need_gen;
    logic [COUNT_WIDTH-1:0] table_size;
    logic [COUNT_WIDTH-1:0] fifo_count;
    logic [COUNT_WIDTH-1:0] live_total;
  } dp_status_t;

endpackage

// ===== hdl/gha_ifs.sv =====
interface gha_req_if;
  logic                              valid;
  logic                              ready;
  logic [gha_pkg::CMD_WIDTH-1:0]     cmd;
  logic [gha_pkg::HANDLE_WIDTH-1:0]  handle_in;

  modport source (output valid, output cmd, output handle_in, input ready);
  modport sink   (input valid, input cmd, input handle_in, output ready);
endinterface

interface gha_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [gha_pkg::HANDLE_WIDTH-1:0]  handle_out;
  logic                              is_alive;
  logic [gha_pkg::STATUS_WIDTH-1:0]  status;
  logic [gha_pkg::COUNT_WIDTH-1:0]   live_count;

  modport source (output valid, output handle_out, output is_alive, output status,
                  output live_count, input ready);
  modport sink   (input valid, input handle_out, input is_alive, input status,
                  input live_count, output ready);
endinterface

// ===== hdl/generational_handle_allocator.sv =====
// Generational handle allocator.
// Requests arrive on the req channel (valid/ready): cmd selects create, destroy,
// alive query or clear all; handle_in carries generation[19:12] and index[11:0].
// Each request produces exactly one beat on the rsp channel: handle_out (new
// handle on create), is_alive, status (ok, dead handle, table full) and the live
// count after the command.
// Timing: a request is taken in the idle state, the generation table and free
// queue are read there, and the update commits in the commit state. A create
// that reuses a freed slot passes through the generation fetch state first: the
// popped index must come out of the free queue memory before its generation can
// be read from the generation table memory (one read port each).
// The response sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following command holds in its commit step
// until the response register drains, then ready comes back.
// Reset (rst, synchronous) empties the table and queue, zeroes the live count and
// loads reuse_threshold with 1024; no memory sweep is needed. cfg_we/cfg_wdata
// write reuse_threshold and are meant to be used only while the block is idle.
module generational_handle_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gha_pkg::COUNT_WIDTH-1:0]  cfg_wdata,
  gha_req_if.sink                          req,
  gha_rsp_if.source                        rsp
);

  gha_pkg::ctl_cmd_t   ctl;
  gha_pkg::dp_status_t stat;

  // sequencing: idle / fetch generation of reused slot / commit
  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // generation table, free queue, counters and the response register
  gha_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (req.cmd),
    .handle_in  (req.handle_in),
    .ctl        (ctl),
    .stat       (stat),
    .handle_out (rsp.handle_out),
    .is_alive   (rsp.is_alive),
    .status     (rsp.status),
    .live_count (rsp.live_count)
  );

`ifndef SYNTH
  // one request in flight: ready drops right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // every live handle and every queued free slot is a distinct table slot
  a_slot_accounting: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, stat.live_total} + {1'b0, stat.fifo_count}) <= {1'b0, stat.table_size})
    else $error("live plus freed slots exceed table size");

  // a table-full response only happens with the table at full depth
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == gha_pkg::ST_FULL)) |->
      (stat.table_size == gha_pkg::SLOT_COUNT))
    else $error("table full reported with room left");
`endif

endmodule

// ===== hdl/gha_ctrl.sv =====
module gha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gha_pkg::dp_status_t stat,
  output gha_pkg::ctl_cmd_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl.accept    = (state == S_IDLE) && in_valid;
    ctl.gen_fetch = (state == S_GEN);
    // commit only when the response register is free or being drained
    ctl.exec      = (state == S_EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.need_gen ? S_GEN : S_EXEC;
          end
        end
        S_GEN: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (ctl.exec) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (ctl.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/gha_dp.sv =====
module gha_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gha_pkg::COUNT_WIDTH-1:0]     cfg_wdata,
  input  logic [gha_pkg::CMD_WIDTH-1:0]       cmd,
  input  logic [gha_pkg::HANDLE_WIDTH-1:0]    handle_in,
  input  gha_pkg::ctl_cmd_t                   ctl,
  output gha_pkg::dp_status_t                 stat,
  output logic [gha_pkg::HANDLE_WIDTH-1:0]    handle_out,
  output logic                                is_alive,
  output logic [gha_pkg::STATUS_WIDTH-1:0]    status,
  output logic [gha_pkg::COUNT_WIDTH-1:0]     live_count
);

  localparam int IW = gha_pkg::INDEX_WIDTH;
  localparam int GW = gha_pkg::GEN_WIDTH;
  localparam int CW = gha_pkg::COUNT_WIDTH;

  // memories
  logic [GW-1:0] gen_mem  [gha_pkg::SLOT_COUNT];
  logic [IW-1:0] fifo_mem [gha_pkg::SLOT_COUNT];
  logic [GW-1:0] gen_rd;
  logic [IW-1:0] fifo_rd;

  // latched request
  gha_pkg::cmd_t cmd_r;
  logic [IW-1:0] idx_r;
  logic [GW-1:0] gen_r;

  // bookkeeping
  logic [CW-1:0] reuse_threshold;
  logic [CW-1:0] table_size, table_size_next;
  logic [IW-1:0] fifo_head, fifo_head_next;
  logic [IW-1:0] fifo_tail, fifo_tail_next;
  logic [CW-1:0] fifo_count, fifo_count_next;
  logic [CW-1:0] live_total, live_total_next;

  logic          gen_we;
  logic [IW-1:0] gen_wa;
  logic [GW-1:0] gen_wd;
  logic          gen_re;
  logic [IW-1:0] gen_ra;
  logic          fifo_we;

  logic                   live_hit;
  logic [GW+IW-1:0]       hout;
  logic                   alive;
  gha_pkg::status_t       st;

  assign stat.need_gen   = (gha_pkg::cmd_t'(cmd) == gha_pkg::CMD_CREATE) &&
                           (fifo_count > reuse_threshold);
  assign stat.table_size = table_size;
  assign stat.fifo_count = fifo_count;
  assign stat.live_total = live_total;

  assign gen_re = ctl.accept || ctl.gen_fetch;
  assign gen_ra = ctl.gen_fetch ? fifo_rd : handle_in[IW-1:0];

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_rd <= gen_mem[gen_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_tail] <= idx_r;
    end
    if (ctl.accept) begin
      fifo_rd <= fifo_mem[fifo_head];
    end
  end

  always_comb begin
    table_size_next = table_size;
    fifo_head_next  = fifo_head;
    fifo_tail_next  = fifo_tail;
    fifo_count_next = fifo_count;
    live_total_next = live_total;
    gen_we          = 1'b0;
    gen_wa          = idx_r;
    gen_wd          = gen_rd + GW'(1);
    fifo_we         = 1'b0;
    hout            = '0;
    alive           = 1'b0;
    st              = gha_pkg::ST_OK;
    live_hit        = ({1'b0, idx_r} < table_size) && (gen_rd == gen_r);

    case (cmd_r)
      gha_pkg::CMD_CREATE: begin
        if (fifo_count > reuse_threshold) begin
          fifo_head_next  = fifo_head + IW'(1);
          fifo_count_next = fifo_count - CW'(1);
          live_total_next = live_total + CW'(1);
          hout            = {gen_rd, fifo_rd};
        end else if (table_size < gha_pkg::SLOT_COUNT) begin
          gen_we          = 1'b1;
          gen_wa          = table_size[IW-1:0];
          gen_wd          = '0;
          table_size_next = table_size + CW'(1);
          live_total_next = live_total + CW'(1);
          hout            = {GW'(0), table_size[IW-1:0]};
        end else begin
          st = gha_pkg::ST_FULL;
        end
      end
      gha_pkg::CMD_DESTROY: begin
        if (!live_hit || (live_total == '0)) begin
          st = gha_pkg::ST_DEAD;
        end else begin
          alive           = 1'b1;
          gen_we          = 1'b1;
          live_total_next = live_total - CW'(1);
          if (live_total_next != '0) begin
            if (fifo_count < gha_pkg::SLOT_COUNT) begin
              fifo_we         = 1'b1;
              fifo_tail_next  = fifo_tail + IW'(1);
              fifo_count_next = fifo_count + CW'(1);
            end
          end else begin
            // last live handle gone: drop the whole table and queue
            table_size_next = '0;
            fifo_head_next  = '0;
            fifo_tail_next  = '0;
            fifo_count_next = '0;
          end
        end
      end
      gha_pkg::CMD_ALIVE: begin
        alive = live_hit;
      end
      default: begin
        table_size_next = '0;
        fifo_head_next  = '0;
        fifo_tail_next  = '0;
        fifo_count_next = '0;
        live_total_next = '0;
      end
    endcase

    if (!ctl.exec) begin
      gen_we  = 1'b0;
      fifo_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= gha_pkg::cmd_t'(cmd);
      idx_r <= handle_in[IW-1:0];
      gen_r <= handle_in[GW+IW-1:IW];
    end
    if (ctl.exec) begin
      handle_out <= hout;
      is_alive   <= alive;
      status     <= st;
      live_count <= live_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_threshold <= gha_pkg::REUSE_RESET;
      table_size      <= '0;
      fifo_head       <= '0;
      fifo_tail       <= '0;
      fifo_count      <= '0;
      live_total      <= '0;
    end else begin
      if (cfg_we) begin
        reuse_threshold <= cfg_wdata;
      end
      if (ctl.exec) begin
        table_size <= table_size_next;
        fifo_head  <= fifo_head_next;
        fifo_tail  <= fifo_tail_next;
        fifo_count <= fifo_count_next;
        live_total <= live_total_next;
      end
    end
  end

endmodule

// ===== sim/gha_scoreboard.sv =====
module gha_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gha_pkg::COUNT_WIDTH-1:0] cfg_wdata,
  gha_req_if                              req,
  gha_rsp_if                              rsp,
  output int                              fail_count,
  output int                              pending
);
  import gha_pkg::*;

  localparam int SLOTS       = 1 << INDEX_WIDTH;
  localparam int TRACK_DEPTH = 8;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic                    alive;
    status_t                 status;
    logic [COUNT_WIDTH-1:0]  live;
  } outcome_t;

  // Shadow copy of the allocator.
  logic [GEN_WIDTH-1:0]   slot_gen [SLOTS];
  logic [INDEX_WIDTH-1:0] freed_slots [SLOTS];
  logic [INDEX_WIDTH-1:0] freed_head, freed_tail;
  logic [COUNT_WIDTH-1:0] freed_count, used_slots, live_now, reuse_limit;

  // Expected response beats, oldest first.
  outcome_t               outcome_mem [TRACK_DEPTH];
  int                     outcome_rd, outcome_wr, outcome_cnt;

  function automatic void wipe_allocator();
    used_slots  = '0;
    freed_head  = '0;
    freed_tail  = '0;
    freed_count = '0;
    live_now    = '0;
  endfunction

  function automatic outcome_t run_command(cmd_t op, logic [HANDLE_WIDTH-1:0] h);
    outcome_t               res;
    logic [INDEX_WIDTH-1:0] idx;
    logic [GEN_WIDTH-1:0]   gen;
    logic [INDEX_WIDTH-1:0] slot;
    logic                   is_live;
    idx     = h[INDEX_WIDTH-1:0];
    gen     = h[HANDLE_WIDTH-1:INDEX_WIDTH];
    is_live = ({1'b0, idx} < used_slots) && (slot_gen[idx] == gen);
    res     = '{handle: '0, alive: 1'b0, status: ST_OK, live: '0};
    case (op)
      CMD_CREATE: begin
        if (freed_count > reuse_limit) begin
          slot        = freed_slots[freed_head];
          freed_head  = freed_head + 1'b1;
          freed_count = freed_count - 1'b1;
          live_now    = live_now + 1'b1;
          res.handle  = {slot_gen[slot], slot};
        end else if (used_slots < SLOT_COUNT) begin
          slot           = used_slots[INDEX_WIDTH-1:0];
          slot_gen[slot] = '0;
          used_slots     = used_slots + 1'b1;
          live_now       = live_now + 1'b1;
          res.handle     = {slot_gen[slot], slot};
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_DESTROY: begin
        if (!is_live || live_now == '0) begin
          res.status = ST_DEAD;
        end else begin
          res.alive     = 1'b1;
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          live_now      = live_now - 1'b1;
          if (live_now != '0) begin
            if (freed_count < SLOT_COUNT) begin
              freed_slots[freed_tail] = idx;
              freed_tail  = freed_tail + 1'b1;
              freed_count = freed_count + 1'b1;
            end
          end else begin
            wipe_allocator();
          end
        end
      end
      CMD_ALIVE: res.alive = is_live;
      default:   wipe_allocator();
    endcase
    res.live = live_now;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      wipe_allocator();
      reuse_limit = REUSE_RESET;
      outcome_rd  = 0;
      outcome_wr  = 0;
      outcome_cnt = 0;
    end else begin
      if (cfg_we) reuse_limit = cfg_wdata;
      // Retire the response beat first; it always belongs to an older request.
      if (rsp.valid && rsp.ready) begin
        got = '{handle: rsp.handle_out, alive: rsp.is_alive,
                status: status_t'(rsp.status), live: rsp.live_count};
        if (outcome_cnt == 0) begin
          fail_count++;
          $display("%0t: expected no beat", $time);
          $display("%0t:   actual handle %h alive %b status %0d live %0d",
                   $time, got.handle, got.alive, got.status, got.live);
        end else begin
          want        = outcome_mem[outcome_rd];
          outcome_rd  = (outcome_rd + 1) % TRACK_DEPTH;
          outcome_cnt = outcome_cnt - 1;
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected handle %h alive %b status %0d live %0d", $time,
                     want.handle, want.alive, want.status, want.live);
            $display("%0t:   actual handle %h alive %b status %0d live %0d", $time,
                     got.handle, got.alive, got.status, got.live);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (outcome_cnt == TRACK_DEPTH) begin
          fail_count++;
          $display("%0t: expected at most %0d requests in flight, actual %0d", $time,
                   TRACK_DEPTH, outcome_cnt + 1);
        end else begin
          outcome_mem[outcome_wr] = run_command(cmd_t'(req.cmd), req.handle_in);
          outcome_wr              = (outcome_wr + 1) % TRACK_DEPTH;
          outcome_cnt             = outcome_cnt + 1;
        end
      end
    end
    pending = outcome_cnt;
  end

endmodule

// ===== sim/generational_handle_allocator_test.sv =====
module generational_handle_allocator_test;
  import gha_pkg::*;

  // Number of cycles the receiver holds off in the back-pressure test.
  localparam int LONG_HOLD = 120;
  localparam int RANDOM_BEATS = 85;
  localparam int POOL_DEPTH = 64;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [COUNT_WIDTH-1:0] cfg_wdata;
  int                     fail_count;
  int                     pending;

  gha_req_if req_ch ();
  gha_rsp_if rsp_ch ();

  generational_handle_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  gha_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stimulus knobs shared between the sender and the receiver processes.
  bit idle_on;       // allow random idle bursts on both channels
  int hold_seq;      // bump to ask the receiver for one long hold-off
  // Handles recently handed out; the oldest entry is overwritten.
  logic [HANDLE_WIDTH-1:0] pool_mem [POOL_DEPTH];
  int                      pool_count;
  int                      pool_wr;

  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(64'd20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: drive ready once per falling edge. A long hold-off, when requested,
  // is counted here; otherwise drop ready in random bursts while idling is on.
  initial begin
    int hold_left;
    int stall_left;
    int hold_seen;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = LONG_HOLD;
      end
      if (!idle_on) stall_left = 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Harvest handles from successful creates so destroys and queries can hit
  // live slots. Keep the pool short so stale handles age out.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
        !rsp_ch.is_alive && rsp_ch.handle_out != '0) begin
      pool_mem[pool_wr] = rsp_ch.handle_out;
      pool_wr = (pool_wr + 1) % POOL_DEPTH;
      if (pool_count < POOL_DEPTH) pool_count = pool_count + 1;
    end
  end

  function automatic logic [HANDLE_WIDTH-1:0] make_handle(logic [GEN_WIDTH-1:0] gen,
                                                          logic [INDEX_WIDTH-1:0] idx);
    return {gen, idx};
  endfunction

  // Offer one request beat and hold it until accepted. Enter and leave at a
  // falling edge; optionally idle the channel for a burst first.
  task automatic send_beat(input cmd_t op, input logic [HANDLE_WIDTH-1:0] h);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= op;
    req_ch.handle_in <= h;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every response beat has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_WIDTH-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly reuse harvested handles (live, or one generation off), sometimes
  // small indices near the bottom of the table, sometimes anything at all.
  task automatic pick_handle(output logic [HANDLE_WIDTH-1:0] h);
    int k;
    int sel;
    sel = $urandom_range(0, 9);
    if (pool_count > 0 && sel < 7) begin
      k = $urandom_range(0, pool_count - 1);
      h = pool_mem[k];
    end else if (pool_count > 0 && sel == 7) begin
      k = $urandom_range(0, pool_count - 1);
      h = pool_mem[k];
      h[HANDLE_WIDTH-1:INDEX_WIDTH] = h[HANDLE_WIDTH-1:INDEX_WIDTH] + 1'b1;
    end else if (sel == 8) begin
      h = make_handle(GEN_WIDTH'($urandom_range(0, 2)), INDEX_WIDTH'($urandom_range(0, 15)));
    end else begin
      h = HANDLE_WIDTH'($urandom);
    end
  endtask

  task automatic random_beat();
    int                      pick;
    logic [HANDLE_WIDTH-1:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_beat(CMD_CREATE, HANDLE_WIDTH'($urandom));
    end else if (pick < 70) begin
      pick_handle(h);
      send_beat(CMD_DESTROY, h);
    end else if (pick < 97) begin
      pick_handle(h);
      send_beat(CMD_ALIVE, h);
    end else begin
      send_beat(CMD_CLEAR, HANDLE_WIDTH'($urandom));
    end
  endtask

  // One random phase under a fixed reuse threshold; the register is only
  // touched after the block has drained.
  task automatic random_phase(input logic [COUNT_WIDTH-1:0] limit, input bit idle,
                              input bit long_hold);
    drain();
    write_threshold(limit);
    idle_on = idle;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (long_hold && i == 30) hold_seq = hold_seq + 1;
      random_beat();
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_CREATE;
    req_ch.handle_in = '0;
    idle_on          = 1'b1;
    hold_seq         = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset threshold: fresh slots only.
    send_beat(CMD_CREATE, '0);
    send_beat(CMD_CREATE, '1);
    send_beat(CMD_CREATE, '0);
    send_beat(CMD_ALIVE, make_handle(8'h00, 12'h000));    // live
    send_beat(CMD_ALIVE, make_handle(8'h01, 12'h000));    // wrong generation
    send_beat(CMD_ALIVE, '1);                             // index past the table
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h001));  // live, bumps generation
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h001));  // dead handle
    send_beat(CMD_ALIVE, make_handle(8'h01, 12'h001));    // bumped generation matches
    send_beat(CMD_DESTROY, '1);                           // out of range
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h000));
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h002));  // last live one empties all
    send_beat(CMD_ALIVE, make_handle(8'h00, 12'h000));
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h000));  // nothing live
    send_beat(CMD_CREATE, '0);
    send_beat(CMD_CLEAR, '0);
    send_beat(CMD_CREATE, '0);

    // Reuse as soon as one freed slot waits.
    drain();
    write_threshold('0);
    send_beat(CMD_CREATE, '0);
    send_beat(CMD_CREATE, '0);
    send_beat(CMD_DESTROY, make_handle(8'h00, 12'h001));
    send_beat(CMD_CREATE, '0);                            // reuses slot 1, generation 1
    send_beat(CMD_CLEAR, '1);

    // Random phases; the first also fills the block with a long receiver hold-off.
    random_phase(COUNT_WIDTH'(0), 1'b1, 1'b1);
    random_phase(COUNT_WIDTH'(2), 1'b1, 1'b0);
    random_phase(SLOT_COUNT, 1'b1, 1'b0);
    random_phase(COUNT_WIDTH'(1), 1'b1, 1'b0);

    // Last phase runs with no idling at all.
    random_phase(COUNT_WIDTH'(3), 1'b0, 1'b0);

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
hdl/gha_pkg.sv
hdl/gha_ifs.sv
hdl/gha_ctrl.sv
hdl/gha_dp.sv
hdl/generational_handle_allocator.sv
sim/gha_scoreboard.sv
sim/generational_handle_allocator_test.sv
